// ----- hdl/rv32i_integer_alu_unit_defines.svh -----
// Assertion macros shared by the RV32I ALU unit RTL.
`ifndef RV32I_INTEGER_ALU_UNIT_DEFINES_SVH
`define RV32I_INTEGER_ALU_UNIT_DEFINES_SVH

// Clocked check, muted while reset is asserted.
`define RIA_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds across reset.
`define RIA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/ria_pkg.sv -----
// Types and constants of the RV32I ALU unit.
package ria_pkg;

  localparam int XLEN    = 32;
  localparam int SHAMT_W = 5;
  localparam int CLS_W   = 2;
  localparam int F3_W    = 3;
  localparam int F7_W    = 7;

  // Instruction classes
  localparam logic [CLS_W-1:0] CLS_ADDR   = 2'd0;
  localparam logic [CLS_W-1:0] CLS_IMM    = 2'd1;
  localparam logic [CLS_W-1:0] CLS_BRANCH = 2'd2;
  localparam logic [CLS_W-1:0] CLS_REG    = 2'd3;

  // funct3 codes
  localparam logic [F3_W-1:0] F3_ADD  = 3'd0;
  localparam logic [F3_W-1:0] F3_SLL  = 3'd1;
  localparam logic [F3_W-1:0] F3_SLT  = 3'd2;
  localparam logic [F3_W-1:0] F3_SLTU = 3'd3;
  localparam logic [F3_W-1:0] F3_XOR  = 3'd4;
  localparam logic [F3_W-1:0] F3_SR   = 3'd5;
  localparam logic [F3_W-1:0] F3_OR   = 3'd6;
  localparam logic [F3_W-1:0] F3_AND  = 3'd7;

  // Branch funct3 codes
  localparam logic [F3_W-1:0] F3_BEQ  = 3'd0;
  localparam logic [F3_W-1:0] F3_BNE  = 3'd1;
  localparam logic [F3_W-1:0] F3_BLT  = 3'd4;
  localparam logic [F3_W-1:0] F3_BGE  = 3'd5;
  localparam logic [F3_W-1:0] F3_BLTU = 3'd6;
  localparam logic [F3_W-1:0] F3_BGEU = 3'd7;

  localparam logic [F7_W-1:0] F7_BASE = 7'b0000000;
  localparam logic [F7_W-1:0] F7_ALT  = 7'b0100000;

  localparam int IMM_ARITH_BIT = 10;
  localparam logic [XLEN-1:0] PC_STEP = 32'd4;

  typedef enum logic [3:0] {
    OP_ADD,
    OP_SUB,
    OP_SLL,
    OP_SLT,
    OP_SLTU,
    OP_XOR,
    OP_SRL,
    OP_SRA,
    OP_OR,
    OP_AND,
    OP_BRANCH
  } op_t;

endpackage

// ----- hdl/ria_if.sv -----
// Valid/ready channel interfaces for the ALU unit input and result beats.
interface ria_in_if;
  import ria_pkg::*;

  logic            valid;
  logic            ready;
  logic [CLS_W-1:0] func;
  logic [F3_W-1:0] funct3;
  logic [F7_W-1:0] funct7;
  logic [XLEN-1:0] operand_a;
  logic [XLEN-1:0] operand_b;
  logic [XLEN-1:0] immediate;
  logic [XLEN-1:0] program_counter;

  modport source (output valid, func, funct3, funct7, operand_a, operand_b, immediate,
                  program_counter, input ready);
  modport sink   (input valid, func, funct3, funct7, operand_a, operand_b, immediate,
                  program_counter, output ready);
endinterface

interface ria_out_if;
  import ria_pkg::*;

  logic            valid;
  logic            ready;
  logic [XLEN-1:0] value;
  logic            illegal;

  modport source (output valid, value, illegal, input ready);
  modport sink   (input valid, value, illegal, output ready);
endinterface

// ----- hdl/rv32i_integer_alu_unit.sv -----
// RV32I integer execute unit: three-stage pipelined ALU with branch target select.
//
//  channel   dir  handshake        payload
//  in_bus    in   valid / ready    func, funct3, funct7, operand_a, operand_b,
//                                  immediate, program_counter
//  out_bus   out  valid / ready    value, illegal
//
// One beat in and one beat out per cycle while out_bus.ready stays high;
// the stages (decode, execute, result select) are each a register.
// rst_n is synchronous, active low, and clears the stage valid bits only.
// Each stage holds while the one after it is full and stalled; bubbles
// collapse, so in_bus.ready drops only when all three stages are full.
`include "rv32i_integer_alu_unit_defines.svh"

module rv32i_integer_alu_unit (
  input  logic      clk,
  input  logic      rst_n,
  ria_in_if.sink    in_bus,
  ria_out_if.source out_bus
);
  import ria_pkg::*;

  // Stage enables
  logic en1, en2, en3;

  // Stage 1: decode
  logic            v1_r;
  op_t             op1_r, op1_nxt;
  logic [F3_W-1:0] f31_r;
  logic            bad1_r, bad1_nxt;
  logic [XLEN-1:0] a1_r, b1_r, b1_nxt, imm1_r, pc1_r;

  // Stage 2: execute
  logic            v2_r;
  op_t             op2_r;
  logic [F3_W-1:0] f32_r;
  logic            bad2_r;
  logic [XLEN-1:0] sum2_r, sum2_nxt;
  logic [XLEN-1:0] shift2_r, shift2_nxt;
  logic [XLEN-1:0] logic2_r, logic2_nxt;
  logic            lt2_r, ltu2_r, eq2_r;
  logic [XLEN-1:0] tgt2_r, seq2_r;

  // Stage 3: result
  logic            v3_r;
  logic [XLEN-1:0] value_r, value_nxt;
  logic            illegal_r;
  logic            take;

  assign en3 = !v3_r || out_bus.ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_bus.ready = en1;

  assign out_bus.valid   = v3_r;
  assign out_bus.value   = value_r;
  assign out_bus.illegal = illegal_r;

  // Decode
  always_comb begin
    op1_nxt  = OP_ADD;
    bad1_nxt = 1'b0;
    b1_nxt   = in_bus.immediate;
    unique case (in_bus.func)
      CLS_ADDR: begin
        op1_nxt = OP_ADD;
      end
      CLS_IMM, CLS_REG: begin
        if (in_bus.func == CLS_REG) b1_nxt = in_bus.operand_b;
        unique case (in_bus.funct3)
          F3_ADD:  op1_nxt = OP_ADD;
          F3_SLL:  op1_nxt = OP_SLL;
          F3_SLT:  op1_nxt = OP_SLT;
          F3_SLTU: op1_nxt = OP_SLTU;
          F3_XOR:  op1_nxt = OP_XOR;
          F3_SR:   op1_nxt = OP_SRL;
          F3_OR:   op1_nxt = OP_OR;
          F3_AND:  op1_nxt = OP_AND;
          default: op1_nxt = OP_ADD;
        endcase
        if (in_bus.func == CLS_IMM) begin
          if (in_bus.funct3 == F3_SR && in_bus.immediate[IMM_ARITH_BIT]) op1_nxt = OP_SRA;
        end else if (in_bus.funct3 == F3_ADD || in_bus.funct3 == F3_SR) begin
          // register form: funct7 must be base or alternate
          if (in_bus.funct7 == F7_ALT) begin
            op1_nxt = (in_bus.funct3 == F3_ADD) ? OP_SUB : OP_SRA;
          end else if (in_bus.funct7 != F7_BASE) begin
            bad1_nxt = 1'b1;
          end
        end
      end
      CLS_BRANCH: begin
        op1_nxt  = OP_BRANCH;
        b1_nxt   = in_bus.operand_b;
        bad1_nxt = (in_bus.funct3 == F3_SLT) || (in_bus.funct3 == F3_SLTU);
      end
      default: op1_nxt = OP_ADD;
    endcase
  end

  // Execute
  always_comb begin
    logic            sub;
    logic [XLEN-1:0] b_eff;
    logic [SHAMT_W-1:0] sh;
    sub   = (op1_r == OP_SUB);
    b_eff = sub ? ~b1_r : b1_r;
    sh    = b1_r[SHAMT_W-1:0];
    sum2_nxt = a1_r + b_eff + XLEN'(sub);
    unique case (op1_r)
      OP_SLL:  shift2_nxt = a1_r << sh;
      OP_SRA:  shift2_nxt = $unsigned($signed(a1_r) >>> sh);
      default: shift2_nxt = a1_r >> sh;
    endcase
    unique case (op1_r)
      OP_XOR:  logic2_nxt = a1_r ^ b1_r;
      OP_OR:   logic2_nxt = a1_r | b1_r;
      default: logic2_nxt = a1_r & b1_r;
    endcase
  end

  // Result select; unsupported combinations read as zero
  always_comb begin
    unique case (f32_r)
      F3_BEQ:  take = eq2_r;
      F3_BNE:  take = !eq2_r;
      F3_BLT:  take = lt2_r;
      F3_BGE:  take = !lt2_r;
      F3_BLTU: take = ltu2_r;
      F3_BGEU: take = !ltu2_r;
      default: take = 1'b0;
    endcase
    unique case (op2_r)
      OP_ADD, OP_SUB:         value_nxt = sum2_r;
      OP_SLL, OP_SRL, OP_SRA: value_nxt = shift2_r;
      OP_SLT:                 value_nxt = XLEN'(lt2_r);
      OP_SLTU:                value_nxt = XLEN'(ltu2_r);
      OP_XOR, OP_OR, OP_AND:  value_nxt = logic2_r;
      OP_BRANCH:              value_nxt = take ? tgt2_r : seq2_r;
      default:                value_nxt = '0;
    endcase
    if (bad2_r) value_nxt = '0;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_bus.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en1) begin
      op1_r  <= op1_nxt;
      f31_r  <= in_bus.funct3;
      bad1_r <= bad1_nxt;
      a1_r   <= in_bus.operand_a;
      b1_r   <= b1_nxt;
      imm1_r <= in_bus.immediate;
      pc1_r  <= in_bus.program_counter;
    end
    if (en2) begin
      op2_r    <= op1_r;
      f32_r    <= f31_r;
      bad2_r   <= bad1_r;
      sum2_r   <= sum2_nxt;
      shift2_r <= shift2_nxt;
      logic2_r <= logic2_nxt;
      lt2_r    <= $signed(a1_r) < $signed(b1_r);
      ltu2_r   <= a1_r < b1_r;
      eq2_r    <= a1_r == b1_r;
      tgt2_r   <= pc1_r + imm1_r;
      seq2_r   <= pc1_r + PC_STEP;
    end
    if (en3) begin
      value_r   <= value_nxt;
      illegal_r <= bad2_r;
    end
  end

  `RIA_ASSERT_CLK(a_illegal_zero, (v3_r && illegal_r) |-> (value_r == '0), "illegal nonzero")
  `RIA_ASSERT_CLK(a_ready_full, !in_bus.ready |-> (v1_r && v2_r && v3_r), "stall with bubble")
  `RIA_ASSERT_CLK(a_s2_hold, (v2_r && !en3) |=> (v2_r && $stable(sum2_r) && $stable(op2_r)), "s2 lost")
  `RIA_ASSERT_RST(a_reset_empty, !rst_n |=> (!v1_r && !v2_r && !v3_r), "pipe not empty")

endmodule
